[design/rvx_pkg.sv]
// Shared constants, types and register write structs for the RV64 subset execute core.
package rvx_pkg;

   // Doubleword store depth; the address is reduced by keeping low bits, so it is a power of two.
   localparam int unsigned DATA_DEPTH = 4096;
   localparam int unsigned DMEM_AW    = $clog2(DATA_DEPTH);

   localparam int unsigned XLEN       = 64;
   localparam int unsigned RF_AW      = 5;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned RSP_USER_W = 3;

   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;

   localparam logic [2:0] F3_DOUBLE  = 3'b011;
   localparam logic [2:0] F3_ZERO    = 3'b000;
   localparam logic [6:0] F7_ZERO    = 7'b0000000;

   localparam logic [RF_AW-1:0] HALT_REG   = 5'd9;
   localparam logic [XLEN-1:0]  HALT_VALUE = 64'd10;

   typedef struct packed {
      logic              en;
      logic [RF_AW-1:0]  idx;
      logic [XLEN-1:0]   data;
   } rvx_rf_wr_type;

   typedef struct packed {
      logic               en;
      logic [DMEM_AW-1:0] idx;
      logic [XLEN-1:0]    data;
   } rvx_dm_wr_type;

endpackage

[design/rv64_subset_execute_core.sv]
// Top level of the RV64 subset execute core (add, addi, ld, sd, beq, jal, jalr).
//
// Usage: each req transaction carries one instruction word fetched at the
// current program counter; each rsp transaction returns exactly one result for
// it, in order: the next fetch address, the register write (if any), a store
// flag and a halt flag (x9 equals 10 after the instruction).
// Timing: an accepted instruction goes from the execute stage into the result
// register; an ld goes on to the load stage, which registers the data store's
// read, and from there into the result register. A new instruction is taken
// only once the last has left both stages; the register file's synchronous
// read must follow the previous instruction's writeback, and ld adds the read.
// Reset: registers, PC and halt flag clear at once; the data store is then
// swept to zero, one doubleword per cycle, 4096 in all, with req_tready low.
// Stall: the result register holds while rsp_tready is low; one more
// instruction may be accepted and waits in the execute stage (ld in the load
// stage) until the result register frees.
module rv64_subset_execute_core import rvx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] instruction
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] next_pc, [36:32] dest_index, [100:37] dest_value, [103:101] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [0] reg_written, [1] store_done, [2] halted
   output logic [RSP_USER_W-1:0]  rsp_tuser
);

   logic                 req_fire;
   logic                 clr_busy;

   logic                 e_valid_ff, e_valid_in;
   logic [31:0]          e_instr_ff;
   logic                 m_valid_ff, m_valid_in;
   logic [RF_AW-1:0]     m_rd_ff;
   logic [31:0]          pc_ff, pc_in;
   logic                 halt_ff, halt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_npc_ff, rsp_npc_in;
   logic [RF_AW-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [XLEN-1:0]      rsp_val_ff, rsp_val_in;
   logic                 rsp_wr_ff, rsp_wr_in;
   logic                 rsp_st_ff, rsp_st_in;
   logic                 rsp_halt_ff, rsp_halt_in;

   logic [XLEN-1:0]      rs1_data, rs2_data, ld_data;
   rvx_rf_wr_type        rf_wr;
   rvx_dm_wr_type        dm_wr;

   logic [6:0]           opc;
   logic [2:0]           f3;
   logic [6:0]           f7;
   logic [RF_AW-1:0]     rd;
   logic                 is_add, is_addi, is_ld, is_sd, is_beq, is_jal, is_jalr;
   logic [XLEN-1:0]      imm_i, imm_s, imm_b, imm_j;
   logic [XLEN-1:0]      sum_ai, sum_as, sum_ab;
   logic [31:0]          pc_plus4;
   logic [31:0]          e_npc;
   logic                 e_writes;
   logic [XLEN-1:0]      e_val;
   logic                 out_free, e_fire, m_fire;

   assign req_tready = !clr_busy && !e_valid_ff && !m_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // ---- decode and execute ----
   assign opc = e_instr_ff[6:0];
   assign rd  = e_instr_ff[11:7];
   assign f3  = e_instr_ff[14:12];
   assign f7  = e_instr_ff[31:25];

   assign is_add  = (opc == OPC_OP) && (f3 == F3_ZERO) && (f7 == F7_ZERO);
   assign is_addi = (opc == OPC_OP_IMM) && (f3 == F3_ZERO);
   assign is_ld   = (opc == OPC_LOAD) && (f3 == F3_DOUBLE);
   assign is_sd   = (opc == OPC_STORE) && (f3 == F3_DOUBLE);
   assign is_beq  = (opc == OPC_BRANCH) && (f3 == F3_ZERO);
   assign is_jal  = (opc == OPC_JAL);
   assign is_jalr = (opc == OPC_JALR) && (f3 == F3_ZERO);

   assign imm_i = {{52{e_instr_ff[31]}}, e_instr_ff[31:20]};
   assign imm_s = {{52{e_instr_ff[31]}}, e_instr_ff[31:25], e_instr_ff[11:7]};
   assign imm_b = {{51{e_instr_ff[31]}}, e_instr_ff[31], e_instr_ff[7],
                   e_instr_ff[30:25], e_instr_ff[11:8], 1'b0};
   assign imm_j = {{43{e_instr_ff[31]}}, e_instr_ff[31], e_instr_ff[19:12],
                   e_instr_ff[20], e_instr_ff[30:21], 1'b0};

   assign sum_ai   = rs1_data + imm_i;
   assign sum_as   = rs1_data + imm_s;
   assign sum_ab   = rs1_data + rs2_data;
   assign pc_plus4 = pc_ff + 32'd4;

   always_comb begin
      e_npc = pc_plus4;
      if (is_beq && (rs1_data == rs2_data)) begin
         e_npc = pc_ff + imm_b[31:0];
      end else if (is_jal) begin
         e_npc = pc_ff + imm_j[31:0];
      end else if (is_jalr) begin
         e_npc = {sum_ai[31:1], 1'b0};
      end
   end

   always_comb begin
      e_val = sum_ab;
      if (is_addi) begin
         e_val = sum_ai;
      end else if (is_jal || is_jalr) begin
         e_val = {32'd0, pc_plus4};
      end
   end

   assign e_writes = (is_add || is_addi || is_jal || is_jalr) && (rd != '0);

   assign out_free = !rsp_valid_ff || rsp_tready;
   // ld leaves for the load stage, which is always empty behind an accept
   assign e_fire   = e_valid_ff && (is_ld || out_free);
   assign m_fire   = m_valid_ff && out_free;

   always_comb begin
      rf_wr.en   = 1'b0;
      rf_wr.idx  = rd;
      rf_wr.data = e_val;
      if (m_fire) begin
         rf_wr.en   = (m_rd_ff != '0);
         rf_wr.idx  = m_rd_ff;
         rf_wr.data = ld_data;
      end else if (e_fire && !is_ld) begin
         rf_wr.en   = e_writes;
      end
   end

   assign dm_wr.en   = e_fire && is_sd;
   assign dm_wr.idx  = sum_as[DMEM_AW-1:0];
   assign dm_wr.data = rs2_data;

   // Tracks x9 == 10 without a third register file port.
   always_comb begin
      halt_in = halt_ff;
      if (rf_wr.en && (rf_wr.idx == HALT_REG)) begin
         halt_in = (rf_wr.data == HALT_VALUE);
      end
   end

   // ---- pipeline control ----
   always_comb begin
      e_valid_in = e_valid_ff;
      m_valid_in = m_valid_ff;
      pc_in      = pc_ff;
      if (req_fire) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
         pc_in      = e_npc;
      end
      if (e_fire && is_ld) begin
         m_valid_in = 1'b1;
      end else if (m_fire) begin
         m_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_npc_in   = rsp_npc_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_wr_in    = rsp_wr_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_halt_in  = rsp_halt_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (m_fire) begin
         // pc_ff already holds the address after the ld
         rsp_valid_in = 1'b1;
         rsp_npc_in   = pc_ff;
         rsp_wr_in    = rf_wr.en;
         rsp_idx_in   = rf_wr.en ? m_rd_ff : '0;
         rsp_val_in   = rf_wr.en ? ld_data : '0;
         rsp_st_in    = 1'b0;
         rsp_halt_in  = halt_in;
      end else if (e_fire && !is_ld) begin
         rsp_valid_in = 1'b1;
         rsp_npc_in   = e_npc;
         rsp_wr_in    = e_writes;
         rsp_idx_in   = e_writes ? rd : '0;
         rsp_val_in   = e_writes ? e_val : '0;
         rsp_st_in    = is_sd;
         rsp_halt_in  = halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         m_valid_ff   <= m_valid_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         e_instr_ff <= req_tdata;
      end
      if (e_fire && is_ld) begin
         m_rd_ff <= rd;
      end
      rsp_npc_ff  <= rsp_npc_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_wr_ff   <= rsp_wr_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_halt_ff <= rsp_halt_in;
   end

   // ---- memories ----
   rvx_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rs1_idx  (req_tdata[19:15]),
      .rs2_idx  (req_tdata[24:20]),
      .wr       (rf_wr),
      .rs1_data (rs1_data),
      .rs2_data (rs2_data)
   );

   rvx_dmem u_dmem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (e_fire && is_ld),
      .rd_idx   (sum_ai[DMEM_AW-1:0]),
      .wr       (dm_wr),
      .rd_data  (ld_data),
      .clr_busy (clr_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_val_ff, rsp_idx_ff, rsp_npc_ff};
   assign rsp_tuser  = {rsp_halt_ff, rsp_st_ff, rsp_wr_ff};

   // ---- assertions ----
   a_accept_enters_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> e_valid_ff)
      else $error("accepted instruction did not enter execute stage");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(e_valid_ff && m_valid_ff))
      else $error("execute and load stages occupied together");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (rf_wr.idx != '0))
      else $error("register file write to x0");

   a_store_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff) |-> !rsp_wr_ff)
      else $error("result flags both a store and a register write");

endmodule

[design/rvx_regfile.sv]
// Integer register file: 32 x 64 synchronous memory, two read ports, one write port.
module rvx_regfile import rvx_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [RF_AW-1:0]     rs1_idx,
   input  logic [RF_AW-1:0]     rs2_idx,
   input  rvx_rf_wr_type        wr,
   output logic [XLEN-1:0]      rs1_data,
   output logic [XLEN-1:0]      rs2_data
);

   logic [XLEN-1:0]      rf_mem [2**RF_AW];
   logic [2**RF_AW-1:0]  valid_ff;
   logic [XLEN-1:0]      rd1_ff;
   logic [XLEN-1:0]      rd2_ff;
   logic                 v1_ff;
   logic                 v2_ff;

   // Entries never written read as zero; x0 is never written.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rf_mem[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd1_ff <= rf_mem[rs1_idx];
         rd2_ff <= rf_mem[rs2_idx];
         v1_ff  <= valid_ff[rs1_idx];
         v2_ff  <= valid_ff[rs2_idx];
      end
   end

   assign rs1_data = v1_ff ? rd1_ff : '0;
   assign rs2_data = v2_ff ? rd2_ff : '0;

endmodule

[design/rvx_dmem.sv]
// Doubleword data store with a clearing sweep after reset.
module rvx_dmem import rvx_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [DMEM_AW-1:0]   rd_idx,
   input  rvx_dm_wr_type        wr,
   output logic [XLEN-1:0]      rd_data,
   output logic                 clr_busy
);

   logic [XLEN-1:0]     dm_mem [DATA_DEPTH];
   logic                clr_active_ff;
   logic                clr_active_in;
   logic [DMEM_AW-1:0]  clr_idx_ff;
   logic [DMEM_AW-1:0]  clr_idx_in;
   logic [XLEN-1:0]     rd_data_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + DMEM_AW'(1);
         if (clr_idx_ff == DMEM_AW'(DATA_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
      end
   end

   // Sweep owns the write port while active; no store can arrive then.
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         dm_mem[clr_idx_ff] <= '0;
      end else if (wr.en) begin
         dm_mem[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= dm_mem[rd_idx];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_active_ff;

endmodule

[sim/rvx_execute_monitor.sv]
// Bus monitor for the RV64 subset core: tracks architectural state, predicts and compares results.
`timescale 1ns / 1ps

module rvx_execute_monitor import rvx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] instruction
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] next_pc, [36:32] dest_index, [100:37] dest_value, [103:101] zero
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] reg_written, [1] store_done, [2] halted
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int unsigned           fail_count,
   output int unsigned           outstanding
);

   typedef struct packed {
      logic [31:0]      next_pc;
      logic             reg_written;
      logic [RF_AW-1:0] dest_index;
      logic [XLEN-1:0]  dest_value;
      logic             store_done;
      logic             halted;
   } exec_result_type;

   logic [XLEN-1:0] arch_regs [32];
   logic [XLEN-1:0] shadow_store [DATA_DEPTH];
   logic [31:0]     arch_pc;
   exec_result_type expected_results [$];
   int unsigned     results_seen;

   // Executes one instruction against the shadow state and returns what the core should report.
   task automatic execute_instr(input logic [31:0] w, output exec_result_type r);
      logic [6:0]      op;
      logic [6:0]      f7;
      logic [2:0]      f3;
      logic [4:0]      rd;
      logic [4:0]      rs1;
      logic [4:0]      rs2;
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] imm_i;
      logic [XLEN-1:0] imm_s;
      logic [XLEN-1:0] imm_b;
      logic [XLEN-1:0] imm_j;
      logic [XLEN-1:0] val;
      logic [XLEN-1:0] addr;
      logic [31:0]     npc;
      logic            wr;
      logic            st;
      begin
         op  = w[6:0];
         rd  = w[11:7];
         f3  = w[14:12];
         rs1 = w[19:15];
         rs2 = w[24:20];
         f7  = w[31:25];
         a   = (rs1 == 5'd0) ? '0 : arch_regs[rs1];
         b   = (rs2 == 5'd0) ? '0 : arch_regs[rs2];
         imm_i = {{52{w[31]}}, w[31:20]};
         imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
         imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         npc = arch_pc + 32'd4;
         wr  = 1'b0;
         st  = 1'b0;
         val = '0;
         if (op == OPC_OP && f3 == F3_ZERO && f7 == F7_ZERO) begin
            wr  = 1'b1;
            val = a + b;
         end else if (op == OPC_OP_IMM && f3 == F3_ZERO) begin
            wr  = 1'b1;
            val = a + imm_i;
         end else if (op == OPC_LOAD && f3 == F3_DOUBLE) begin
            addr = a + imm_i;
            wr   = 1'b1;
            val  = shadow_store[addr[DMEM_AW-1:0]];
         end else if (op == OPC_STORE && f3 == F3_DOUBLE) begin
            addr = a + imm_s;
            shadow_store[addr[DMEM_AW-1:0]] = b;
            st = 1'b1;
         end else if (op == OPC_BRANCH && f3 == F3_ZERO) begin
            if (a == b)
               npc = arch_pc + imm_b[31:0];
         end else if (op == OPC_JAL) begin
            wr  = 1'b1;
            val = {32'd0, arch_pc + 32'd4};
            npc = arch_pc + imm_j[31:0];
         end else if (op == OPC_JALR && f3 == F3_ZERO) begin
            addr = a + imm_i;
            wr   = 1'b1;
            val  = {32'd0, arch_pc + 32'd4};
            npc  = {addr[31:1], 1'b0};
         end
         // writes to x0 are dropped and reported as no write
         if (wr && rd != 5'd0) begin
            arch_regs[rd] = val;
         end else begin
            wr  = 1'b0;
            rd  = 5'd0;
            val = '0;
         end
         arch_pc = npc;
         r.next_pc     = npc;
         r.reg_written = wr;
         r.dest_index  = rd;
         r.dest_value  = val;
         r.store_done  = st;
         r.halted      = (arch_regs[HALT_REG] == HALT_VALUE);
      end
   endtask

   always @(posedge clock) begin : watch
      exec_result_type want;
      exec_result_type got;
      if (reset) begin
         for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
         for (int i = 0; i < DATA_DEPTH; i++)
            shadow_store[i] = '0;
         arch_pc = '0;
         expected_results.delete();
         results_seen = 0;
         fail_count   = 0;
         outstanding  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.next_pc     = rsp_tdata[31:0];
            got.dest_index  = rsp_tdata[36:32];
            got.dest_value  = rsp_tdata[100:37];
            got.reg_written = rsp_tuser[0];
            got.store_done  = rsp_tuser[1];
            got.halted      = rsp_tuser[2];
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result %0d arrived with nothing pending", $realtime,
                           results_seen);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result %0d differs", $realtime, results_seen);
                     $display("   expected pc %h wr %b rd %0d val %h st %b halt %b",
                              want.next_pc, want.reg_written, want.dest_index,
                              want.dest_value, want.store_done, want.halted);
                     $display("   actual   pc %h wr %b rd %0d val %h st %b halt %b",
                              got.next_pc, got.reg_written, got.dest_index,
                              got.dest_value, got.store_done, got.halted);
                  end
               end
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            execute_instr(req_tdata, want);
            expected_results.push_back(want);
         end
         outstanding = expected_results.size();
      end
   end

endmodule

[sim/testbench.sv]
// Top of the RV64 subset core testbench: clock, reset, instruction stream and verdict.
`timescale 1ns / 1ps

module testbench;
   import rvx_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam logic [6:0]  F7_ALT         = 7'b0100000;   // sub, not in the subset
   localparam logic [2:0]  F3_ALT         = 3'b001;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata    = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned idle_cycles  = 0;
   int unsigned hold_left    = 0;
   logic        hold_done    = 1'b0;
   logic        hold_request = 1'b0;
   logic        quiet        = 1'b0;

   always #4 clock = ~clock;

   rv64_subset_execute_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rvx_execute_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic logic [31:0] enc_r(input logic [6:0] f7,
                                         input logic [4:0] rd, rs1, rs2);
      return {f7, rs2, rs1, F3_ZERO, rd, OPC_OP};
   endfunction

   function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                         input logic [4:0] rd, rs1,
                                         input logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1, rs2,
                                         input logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1, rs2,
                                         input logic [12:0] imm);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   // mostly a handful of low registers so instructions feed each other
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(7) == 0)
         return 5'($urandom_range(31));
      return 5'($urandom_range(9));
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [11:0] imm;
      int unsigned pick;
      begin
         rd   = pick_reg();
         rs1  = pick_reg();
         rs2  = pick_reg();
         imm  = 12'($urandom());
         pick = $urandom_range(99);
         if (pick < 18) begin
            w = enc_r(F7_ZERO, rd, rs1, rs2);
         end else if (pick < 36) begin
            if ($urandom_range(9) == 0)
               w = enc_i(OPC_OP_IMM, F3_ZERO, HALT_REG, 5'd0, 12'd10);
            else
               w = enc_i(OPC_OP_IMM, F3_ZERO, rd, rs1, imm);
         end else if (pick < 64) begin
            // keep most addresses low so loads find earlier stores
            if ($urandom_range(3) != 0) begin
               rs1 = 5'd0;
               imm = 12'($urandom_range(31));
            end
            if (pick < 50)
               w = enc_i(OPC_LOAD, F3_DOUBLE, rd, rs1, imm);
            else
               w = enc_s(F3_DOUBLE, rs1, rs2, imm);
         end else if (pick < 74) begin
            if ($urandom_range(2) == 0)
               rs2 = rs1;
            w = enc_b(F3_ZERO, rs1, rs2, {imm, 1'b0});
         end else if (pick < 82) begin
            w = enc_j(rd, 21'($urandom()));
         end else if (pick < 90) begin
            w = enc_i(OPC_JALR, F3_ZERO, rd, rs1, imm);
         end else if (pick < 95) begin
            // known opcode, random funct bits
            w = $urandom();
            case ($urandom_range(5))
               0:       w[6:0] = OPC_OP;
               1:       w[6:0] = OPC_OP_IMM;
               2:       w[6:0] = OPC_LOAD;
               3:       w[6:0] = OPC_STORE;
               4:       w[6:0] = OPC_BRANCH;
               default: w[6:0] = OPC_JALR;
            endcase
         end else begin
            w = $urandom();
         end
         return w;
      end
   endfunction

   task automatic send_instr(input logic [31:0] word);
      begin
         while (!quiet && $urandom_range(99) < 6) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= word;
         @(posedge clock);
         while (!req_tready)
            @(posedge clock);
         @(negedge clock);
      end
   endtask

   // result side: random back-pressure plus one long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   // covers the store sweep after reset, during which the core accepts nothing
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_instr(enc_i(OPC_OP_IMM, F3_ZERO, 5'd1, 5'd0, 12'h7FF));   // largest imm
      send_instr(enc_i(OPC_OP_IMM, F3_ZERO, 5'd2, 5'd0, 12'h800));   // smallest imm
      send_instr(enc_r(F7_ZERO, 5'd3, 5'd1, 5'd2));                  // all ones
      send_instr(enc_r(F7_ZERO, 5'd4, 5'd3, 5'd3));                  // wraps
      send_instr(enc_i(OPC_OP_IMM, F3_ZERO, 5'd5, 5'd3, 12'h001));   // wraps to zero
      send_instr(enc_s(F3_DOUBLE, 5'd0, 5'd3, 12'hFFF));             // last doubleword
      send_instr(enc_s(F3_DOUBLE, 5'd2, 5'd1, 12'h000));
      send_instr(enc_i(OPC_LOAD, F3_DOUBLE, 5'd6, 5'd0, 12'hFFF));
      send_instr(enc_i(OPC_LOAD, F3_DOUBLE, 5'd7, 5'd2, 12'h000));
      send_instr(enc_i(OPC_LOAD, F3_DOUBLE, 5'd0, 5'd0, 12'hFFF));   // load into x0
      send_instr(enc_i(OPC_OP_IMM, F3_ZERO, HALT_REG, 5'd0, 12'd10));
      send_instr(enc_r(F7_ZERO, 5'd0, 5'd1, 5'd1));                  // add into x0
      send_instr(enc_b(F3_ZERO, 5'd0, 5'd0, 13'h1000));              // taken, back 4096
      send_instr(enc_b(F3_ZERO, 5'd1, 5'd2, 13'h0FFE));              // not taken
      send_instr(enc_b(F3_ZERO, 5'd1, 5'd1, 13'h0FFE));              // taken, forward
      send_instr(enc_j(5'd1, 21'h0FFFFE));
      send_instr(enc_j(5'd0, 21'h100000));                           // no link
      send_instr(enc_i(OPC_JALR, F3_ZERO, 5'd10, 5'd3, 12'hFFF));    // even target
      send_instr(enc_i(OPC_JALR, F3_ZERO, 5'd0, 5'd0, 12'h7FF));
      send_instr(enc_r(F7_ALT, 5'd11, 5'd1, 5'd2));
      send_instr(enc_i(OPC_LOAD, F3_ZERO, 5'd12, 5'd0, 12'h000));
      send_instr(enc_s(F3_ZERO, 5'd0, 5'd1, 12'h010));
      send_instr(enc_b(F3_ALT, 5'd1, 5'd2, 13'h0010));
      send_instr(enc_i(OPC_OP_IMM, F3_ALT, 5'd13, 5'd1, 12'h001));
      send_instr(enc_i(OPC_JALR, F3_ALT, 5'd14, 5'd1, 12'h000));
      send_instr(32'h0000_0000);
      send_instr(32'hFFFF_FFFF);

      for (n = 0; n < 1000; n++) begin
         quiet = (n >= 400 && n < 600);
         if (n == 200)
            hold_request = 1'b1;
         if (n == 700) begin
            // drain the core completely before resuming
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (outstanding != 0)
               @(negedge clock);
         end
         send_instr(random_instr());
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
